// ===== rtl/core/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int SLOT_W      = 2;
    localparam int RANK_MAX_W  = 4;
    localparam int EVICT_W     = 16;
    localparam int COUNT_W     = 32;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [RANK_MAX_W-1:0] rank_t;
    typedef logic [EVICT_W-1:0]    evict_page_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // collected along the row of cells, one cell at a time
    typedef struct packed {
        logic        hit;
        rank_t       hit_rank;
        slot_t       hit_slot;
        logic        empty_seen;
        slot_t       empty_slot;
        slot_t       victim_slot;
        evict_page_t victim_page;
    } chain_t;

    // broadcast to every cell
    typedef struct packed {
        logic  load;
        logic  clear;
        logic  hit;
        rank_t hit_rank;
        logic  full;
    } cmd_t;

endpackage

// ===== rtl/core/lrupr_cell.sv =====
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16,
    parameter int IDX         = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PAGE_BITS-1:0] page_in,
    input  cmd_t                 cmd,
    input  chain_t               chain_in,
    output chain_t               chain_out
);

    localparam int RANK_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(FRAME_COUNT - 1);
    localparam slot_t MY_SLOT = SLOT_W'(IDX);

    logic [PAGE_BITS-1:0]         page_reg;
    logic [PAGE_BITS-1:0]         page_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic [RANK_W-1:0]            rank_reg;
    logic [RANK_W-1:0]            rank_next;
    logic [PAGE_BITS+EVICT_W-1:0] page_ext;
    rank_t                        rank_wide;
    logic                         match;
    logic                         first_empty;
    logic                         victim;
    logic                         take;

    assign page_ext    = {{EVICT_W{1'b0}}, page_reg};
    assign rank_wide   = RANK_MAX_W'(rank_reg);
    assign match       = valid_reg && (page_reg == page_in);
    assign first_empty = !valid_reg && !chain_in.empty_seen;
    assign victim      = valid_reg && (rank_reg == RANK_OLDEST);
    assign take        = cmd.full ? victim : first_empty;

    always_comb
    begin
        chain_out.hit         = chain_in.hit | match;
        chain_out.hit_rank    = chain_in.hit_rank | (match ? rank_wide : '0);
        chain_out.hit_slot    = chain_in.hit_slot | (match ? MY_SLOT : '0);
        chain_out.empty_seen  = chain_in.empty_seen | !valid_reg;
        chain_out.empty_slot  = chain_in.empty_slot | (first_empty ? MY_SLOT : '0);
        chain_out.victim_slot = chain_in.victim_slot | (victim ? MY_SLOT : '0);
        chain_out.victim_page = chain_in.victim_page
                              | (victim ? page_ext[EVICT_W-1:0] : '0);
    end

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.load)
        begin
            if (cmd.clear)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            else if (cmd.hit)
            begin
                if (match)
                    rank_next = '0;
                else if (valid_reg && (rank_wide < cmd.hit_rank))
                    rank_next = rank_reg + 1'b1;
            end
            else if (take)
            begin
                page_next  = page_in;
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// result: registered on the output register in the cycle after the input transfer
// throughput: one reference per cycle while in_stall is low, set by the combinational row of frame cells
// a new reference is taken while the previous result is being taken downstream
// reset: all frames empty, ranks and hit/fault totals zero, no result pending
// a reference flagged as last also returns frames, ranks and totals to the reset values
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] page_number,
    input  logic                 last_page,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output slot_t                frame_slot,
    output logic                 evicted_valid,
    output evict_page_t          evicted_page,
    output count_t               hit_count,
    output count_t               fault_count
);

    chain_t chain [FRAME_COUNT+1];
    cmd_t   cmd;
    logic   accept;
    logic   full;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        hit_reg;
    slot_t       slot_reg;
    logic        ev_valid_reg;
    evict_page_t ev_page_reg;
    count_t      hit_out_reg;
    count_t      fault_out_reg;
    count_t      hit_total_reg;
    count_t      hit_total_next;
    count_t      fault_total_reg;
    count_t      fault_total_next;
    count_t      hit_sum;
    count_t      fault_sum;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign chain[0] = '0;
    assign full     = !chain[FRAME_COUNT].empty_seen;

    always_comb
    begin
        cmd.load     = accept;
        cmd.clear    = last_page;
        cmd.hit      = chain[FRAME_COUNT].hit;
        cmd.hit_rank = chain[FRAME_COUNT].hit_rank;
        cmd.full     = full;
    end

    for (genvar i = 0; i < FRAME_COUNT; i++)
    begin : g_cell
        lrupr_cell #(
            .FRAME_COUNT(FRAME_COUNT),
            .PAGE_BITS  (PAGE_BITS),
            .IDX        (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .page_in  (page_number),
            .cmd      (cmd),
            .chain_in (chain[i]),
            .chain_out(chain[i+1])
        );
    end

    // saturating totals
    always_comb
    begin
        hit_sum   = hit_total_reg;
        fault_sum = fault_total_reg;
        if (chain[FRAME_COUNT].hit)
        begin
            if (hit_total_reg != '1)
                hit_sum = hit_total_reg + 1'b1;
        end
        else if (fault_total_reg != '1)
        begin
            fault_sum = fault_total_reg + 1'b1;
        end
    end

    always_comb
    begin
        hit_total_next   = hit_total_reg;
        fault_total_next = fault_total_reg;
        if (accept)
        begin
            hit_total_next   = last_page ? '0 : hit_sum;
            fault_total_next = last_page ? '0 : fault_sum;
        end
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            hit_total_reg   <= hit_total_next;
            fault_total_reg <= fault_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg       <= chain[FRAME_COUNT].hit;
            hit_out_reg   <= hit_sum;
            fault_out_reg <= fault_sum;
            if (chain[FRAME_COUNT].hit)
            begin
                slot_reg     <= chain[FRAME_COUNT].hit_slot;
                ev_valid_reg <= 1'b0;
                ev_page_reg  <= '0;
            end
            else if (full)
            begin
                slot_reg     <= chain[FRAME_COUNT].victim_slot;
                ev_valid_reg <= 1'b1;
                ev_page_reg  <= chain[FRAME_COUNT].victim_page;
            end
            else
            begin
                slot_reg     <= chain[FRAME_COUNT].empty_slot;
                ev_valid_reg <= 1'b0;
                ev_page_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_count     = hit_out_reg;
    assign fault_count   = fault_out_reg;

endmodule

// ===== tb/sv/tb_lru_page_replacement.sv =====
module tb_lru_page_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    localparam int FRAMES     = 4;
    localparam int PAGE_W     = 16;
    localparam int RAND_REFS  = 1200;
    localparam int HOLD_OFF   = 150;

    typedef struct {
        logic        hit;
        slot_t       slot;
        logic        evicted_valid;
        evict_page_t evicted_page;
        count_t      hits;
        count_t      faults;
    } page_result_t;

    class lru_scoreboard;
        page_result_t        expected_q[$];
        logic [PAGE_W-1:0]   frame_page[FRAMES];
        bit                  frame_valid[FRAMES];
        int unsigned         frame_rank[FRAMES];
        count_t              hit_total;
        count_t              fault_total;
        int                  mismatches;

        function new();
            flush_frames();
            mismatches = 0;
        endfunction

        function void flush_frames();
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                frame_rank[i]  = 0;
            end
            hit_total   = '0;
            fault_total = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted reference, one predicted result
        function void note_reference(logic [PAGE_W-1:0] page, logic last);
            page_result_t r;
            int           slot;
            int unsigned  old_rank;
            int unsigned  limit;
            slot = -1;
            r.evicted_valid = 1'b0;
            r.evicted_page  = '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (slot < 0 && frame_valid[i] && frame_page[i] == page)
                    slot = i;
            end
            if (slot >= 0)
            begin
                old_rank = frame_rank[slot];
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (frame_valid[i] && frame_rank[i] < old_rank)
                        frame_rank[i]++;
                end
                frame_rank[slot] = 0;
                r.hit = 1'b1;
                if (hit_total != '1)
                    hit_total++;
            end
            else
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (slot < 0 && !frame_valid[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    slot = 0;
                    for (int i = 1; i < FRAMES; i++)
                    begin
                        if (frame_rank[i] > frame_rank[slot])
                            slot = i;
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = evict_page_t'(frame_page[slot]);
                end
                limit = r.evicted_valid ? frame_rank[slot] : 256;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (i != slot && frame_valid[i] && frame_rank[i] < limit)
                        frame_rank[i]++;
                end
                frame_page[slot]  = page;
                frame_valid[slot] = 1'b1;
                frame_rank[slot]  = 0;
                r.hit = 1'b0;
                if (fault_total != '1)
                    fault_total++;
            end
            r.slot   = slot_t'(slot);
            r.hits   = hit_total;
            r.faults = fault_total;
            expected_q.push_back(r);
            if (last)
                flush_frames();
        endfunction

        function void check_result(page_result_t act);
            page_result_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: hit=%0b slot=%0d ev=%0b/%h",
                             $time, act.hit, act.slot, act.evicted_valid, act.evicted_page);
                return;
            end
            exp = expected_q.pop_front();
            if (act.hit !== exp.hit || act.slot !== exp.slot
                || act.evicted_valid !== exp.evicted_valid
                || act.evicted_page !== exp.evicted_page
                || act.hits !== exp.hits || act.faults !== exp.faults)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch exp hit=%0b slot=%0d ev=%0b/%h hits=%0d faults=%0d",
                             $time, exp.hit, exp.slot, exp.evicted_valid, exp.evicted_page,
                             exp.hits, exp.faults);
                    $display("%0t:          act hit=%0b slot=%0d ev=%0b/%h hits=%0d faults=%0d",
                             $time, act.hit, act.slot, act.evicted_valid, act.evicted_page,
                             act.hits, act.faults);
                end
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [PAGE_W-1:0]   page_number   = '0;
    logic                last_page     = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                hit;
    slot_t               frame_slot;
    logic                evicted_valid;
    evict_page_t         evicted_page;
    count_t              hit_count;
    count_t              fault_count;

    lru_scoreboard       sb;
    int                  refs_sent     = 0;
    int                  results_taken = 0;

    lru_page_replacement #(
        .FRAME_COUNT (FRAMES),
        .PAGE_BITS   (PAGE_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .last_page     (last_page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_count     (hit_count),
        .fault_count   (fault_count)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        page_result_t act;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                act.hit           = hit;
                act.slot          = frame_slot;
                act.evicted_valid = evicted_valid;
                act.evicted_page  = evicted_page;
                act.hits          = hit_count;
                act.faults        = fault_count;
                sb.check_result(act);
            end
            if (in_valid && !in_stall)
                sb.note_reference(page_number, last_page);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_ref(logic [PAGE_W-1:0] page, logic last);
        int gap;
        gap = (((refs_sent / 64) % 3) == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        last_page   <= last;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        refs_sent++;
        @(negedge clk);
    endtask

    task automatic send_sequence();
        logic [PAGE_W-1:0] working_set[8];
        logic [PAGE_W-1:0] page;
        int                len;
        int                set_size;
        int                noise;
        noise    = ($urandom_range(0, 9) == 0);
        len      = noise ? $urandom_range(1, 3) : $urandom_range(4, 40);
        set_size = $urandom_range(2, 8);
        for (int i = 0; i < 8; i++)
            working_set[i] = PAGE_W'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++)
        begin
            if (noise || $urandom_range(0, 9) == 0)
                page = PAGE_W'($urandom_range(0, 65535));
            else
                page = working_set[3'($urandom_range(0, set_size - 1))];
            send_ref(page, i == len - 1);
        end
    endtask

    // receiver, with one long hold-off to back the block up
    initial
    begin
        int  wait_cycles;
        bit  held_off;
        held_off = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && results_taken >= 400)
            begin
                wait_cycles = HOLD_OFF;
                held_off    = 1;
            end
            else if (((results_taken / 50) % 3) == 2)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // page zero against empty frames, then fill, hit and evict
        send_ref(16'h0000, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'hAAAA, 1'b1);
        // state cleared: page zero must miss into frame zero
        send_ref(16'h0000, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h0000, 1'b1);
        send_ref(16'hFFFF, 1'b1);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'hFFFF, 1'b1);

        while (refs_sent < RAND_REFS + 20)
            send_sequence();
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
